/* sv/prim_mst_pkg.sv */
package prim_mst_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int WEIGHT_BITS_DEF  = 16;

    localparam int CFG_W     = 7;
    localparam int VERTEX_W  = 6;
    localparam int WEIGHT_W  = 16;
    localparam int TOTAL_W   = 22;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 24;

    localparam logic [CFG_W-1:0] NUM_VERTICES_RST = 7'd64;

    typedef struct packed {
        logic [TOTAL_W-1:0] total_weight;
        logic               disconnected;
    } mst_result_t;

endpackage

/* sv/prim_mst_matrix.sv */
module prim_mst_matrix
    import prim_mst_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                clear_start,
    output logic                                clear_busy,
    input  logic                                wr_en,
    input  logic [$clog2(MAX_VERTICES)-1:0]     wr_a,
    input  logic [$clog2(MAX_VERTICES)-1:0]     wr_b,
    input  logic [WEIGHT_BITS-1:0]              wr_data,
    input  logic                                rd_en,
    input  logic [$clog2(MAX_VERTICES)-1:0]     rd_a,
    input  logic [$clog2(MAX_VERTICES)-1:0]     rd_b,
    output logic [WEIGHT_BITS-1:0]              rd_data
);

    localparam int VTX_W  = $clog2(MAX_VERTICES);
    localparam int ADDR_W = 2 * VTX_W;
    localparam int DEPTH  = 1 << ADDR_W;

    // only the upper triangle is kept, both directions share one entry
    function automatic logic [ADDR_W-1:0] pair_addr(input logic [VTX_W-1:0] a,
                                                    input logic [VTX_W-1:0] b);
        logic [ADDR_W-1:0] addr;
        if (a <= b) begin
            addr = {a, b};
        end else begin
            addr = {b, a};
        end
        return addr;
    endfunction

    logic [WEIGHT_BITS-1:0] mem [DEPTH];
    logic [WEIGHT_BITS-1:0] rd_data_reg;

    logic              clr_busy_reg, clr_busy_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;

    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    logic [WEIGHT_BITS-1:0] mem_wdata;

    always_comb begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clear_start) begin
            clr_busy_next = 1'b1;
            clr_addr_next = '0;
        end else if (clr_busy_reg) begin
            clr_addr_next = clr_addr_reg + ADDR_W'(1);
            if (&clr_addr_reg) begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_comb begin
        if (clr_busy_reg) begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end else begin
            mem_we    = wr_en;
            mem_waddr = pair_addr(wr_a, wr_b);
            mem_wdata = wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            rd_data_reg <= mem[pair_addr(rd_a, rd_b)];
        end
    end

    assign clear_busy = clr_busy_reg;
    assign rd_data    = rd_data_reg;

endmodule

/* sv/prim_mst_tree.sv */
module prim_mst_tree
    import prim_mst_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [$clog2(MAX_VERTICES+1)-1:0]   n_used,
    output logic                                mat_rd_en,
    output logic [$clog2(MAX_VERTICES)-1:0]     mat_rd_a,
    output logic [$clog2(MAX_VERTICES)-1:0]     mat_rd_b,
    input  logic [WEIGHT_BITS-1:0]              mat_rd_data,
    output logic                                res_valid,
    input  logic                                res_ack,
    output mst_result_t                         result
);

    localparam int VTX_W  = $clog2(MAX_VERTICES);
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int KEY_W  = WEIGHT_BITS + 1;
    localparam int ENT_W  = KEY_W + 1;
    localparam int KDEPTH = 1 << VTX_W;

    localparam logic [KEY_W-1:0] KEY_UNREACHED = KEY_W'(1) << WEIGHT_BITS;

    localparam logic [2:0] T_IDLE = 3'd0;
    localparam logic [2:0] T_INIT = 3'd1;
    localparam logic [2:0] T_SCAN = 3'd2;
    localparam logic [2:0] T_PICK = 3'd3;
    localparam logic [2:0] T_DONE = 3'd4;

    // entry: tree mark on top, cheapest known edge into the tree below
    logic [ENT_W-1:0] key_mem [KDEPTH];
    logic [ENT_W-1:0] kd_reg;

    logic [2:0]         state_reg, state_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   added_reg, added_next;
    logic [VTX_W-1:0]   u_reg, u_next;
    logic               upd_reg, upd_next;
    logic [KEY_W-1:0]   best_reg, best_next;
    logic [VTX_W-1:0]   best_idx_reg, best_idx_next;
    logic               found_reg, found_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic               gap_reg, gap_next;
    logic               p_valid_reg, p_valid_next;
    logic [VTX_W-1:0]   p_idx_reg, p_idx_next;

    logic             km_we;
    logic [VTX_W-1:0] km_waddr;
    logic [ENT_W-1:0] km_wdata;
    logic             km_re;

    logic             kd_in;
    logic [KEY_W-1:0] kd_key;
    logic [KEY_W-1:0] w_ext;
    logic             relax;
    logic [KEY_W-1:0] new_key;

    assign kd_in   = kd_reg[KEY_W];
    assign kd_key  = kd_reg[KEY_W-1:0];
    assign w_ext   = KEY_W'(mat_rd_data);
    assign relax   = upd_reg && (mat_rd_data != '0) && !kd_in && (w_ext < kd_key);
    assign new_key = relax ? w_ext : kd_key;

    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        added_next    = added_reg;
        u_next        = u_reg;
        upd_next      = upd_reg;
        best_next     = best_reg;
        best_idx_next = best_idx_reg;
        found_next    = found_reg;
        total_next    = total_reg;
        gap_next      = gap_reg;
        p_valid_next  = 1'b0;
        p_idx_next    = p_idx_reg;
        km_we         = 1'b0;
        km_waddr      = idx_reg[VTX_W-1:0];
        km_wdata      = '0;
        km_re         = 1'b0;

        unique case (state_reg)
            T_IDLE: begin
                if (start) begin
                    state_next = T_INIT;
                    idx_next   = '0;
                    added_next = '0;
                    total_next = '0;
                    gap_next   = 1'b0;
                    upd_next   = 1'b0;
                end
            end
            T_INIT: begin
                km_we    = 1'b1;
                km_wdata = {1'b0, (idx_reg == '0) ? KEY_W'(0) : KEY_UNREACHED};
                idx_next = idx_reg + CNT_W'(1);
                if (idx_reg == n_used - CNT_W'(1)) begin
                    state_next = T_SCAN;
                    idx_next   = '0;
                    best_next  = KEY_UNREACHED;
                    found_next = 1'b0;
                end
            end
            T_SCAN: begin
                // issue stage: read key and matrix entry of the next vertex
                if (idx_reg != n_used) begin
                    km_re        = 1'b1;
                    p_valid_next = 1'b1;
                    p_idx_next   = idx_reg[VTX_W-1:0];
                    idx_next     = idx_reg + CNT_W'(1);
                end
                // update stage: relax against the last added vertex, track minimum
                if (p_valid_reg) begin
                    km_we    = 1'b1;
                    km_waddr = p_idx_reg;
                    km_wdata = {kd_in, new_key};
                    if (!kd_in && (new_key < best_reg)) begin
                        best_next     = new_key;
                        best_idx_next = p_idx_reg;
                        found_next    = 1'b1;
                    end
                end else if (idx_reg == n_used) begin
                    state_next = T_PICK;
                end
            end
            T_PICK: begin
                if (!found_reg) begin
                    gap_next   = 1'b1;
                    state_next = T_DONE;
                end else begin
                    km_we      = 1'b1;
                    km_waddr   = best_idx_reg;
                    km_wdata   = {1'b1, best_reg};
                    total_next = total_reg + TOTAL_W'(best_reg);
                    u_next     = best_idx_reg;
                    upd_next   = 1'b1;
                    added_next = added_reg + CNT_W'(1);
                    if (CNT_W'(added_reg + CNT_W'(1)) == n_used) begin
                        state_next = T_DONE;
                    end else begin
                        state_next = T_SCAN;
                        idx_next   = '0;
                        best_next  = KEY_UNREACHED;
                        found_next = 1'b0;
                    end
                end
            end
            T_DONE: begin
                if (res_ack) begin
                    state_next = T_IDLE;
                end
            end
            default: begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= T_IDLE;
            p_valid_reg <= 1'b0;
            upd_reg     <= 1'b0;
            found_reg   <= 1'b0;
            gap_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            p_valid_reg <= p_valid_next;
            upd_reg     <= upd_next;
            found_reg   <= found_next;
            gap_reg     <= gap_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        added_reg    <= added_next;
        u_reg        <= u_next;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        total_reg    <= total_next;
        p_idx_reg    <= p_idx_next;
    end

    always_ff @(posedge aclk) begin
        if (km_we) begin
            key_mem[km_waddr] <= km_wdata;
        end
        if (km_re) begin
            kd_reg <= key_mem[idx_reg[VTX_W-1:0]];
        end
    end

    assign mat_rd_en = km_re;
    assign mat_rd_a  = u_reg;
    assign mat_rd_b  = idx_reg[VTX_W-1:0];

    assign res_valid           = (state_reg == T_DONE);
    assign result.total_weight = total_reg;
    assign result.disconnected = gap_reg;

endmodule

/* sv/prim_mst_weight_core.sv */
// input: edge words are taken one per cycle while the core is in its load state; after the last
// word the key entries of the n vertices in use are set up, then up to n key scans run
// output: one result per graph; after each result all (2**clog2(MAX_VERTICES))**2 matrix
// entries (4096 at the default size) are swept clear before words are taken again
// reset: aresetn synchronous active low; num_vertices returns to 64 and the same clearing
// sweep runs after reset before the first word is accepted
module prim_mst_weight_core
    import prim_mst_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // src_vertex, dst_vertex, weight
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // total_weight
    output logic                 m_tuser,   // disconnected
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int VTX_W = $clog2(MAX_VERTICES);
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int NC_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_LOAD  = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CFG_W-1:0] num_vertices_reg;

    logic               out_valid_reg, out_valid_next;
    logic [TOTAL_W-1:0] out_total_reg;
    logic               out_gap_reg;

    logic [VERTEX_W-1:0] src_vertex;
    logic [VERTEX_W-1:0] dst_vertex;
    logic [WEIGHT_W-1:0] weight;
    logic                s_accept;
    logic                in_range;

    logic [NC_W-1:0]  nv_ext;
    logic [CNT_W-1:0] n_used;

    logic        clear_start;
    logic        clear_busy;
    logic        tree_start;
    logic        res_valid;
    logic        res_ack;
    mst_result_t result;

    logic                   mat_rd_en;
    logic [VTX_W-1:0]       mat_rd_a;
    logic [VTX_W-1:0]       mat_rd_b;
    logic [WEIGHT_BITS-1:0] mat_rd_data;

    assign src_vertex = s_tdata[VERTEX_W-1:0];
    assign dst_vertex = s_tdata[2*VERTEX_W-1:VERTEX_W];
    assign weight     = s_tdata[2*VERTEX_W+WEIGHT_W-1:2*VERTEX_W];

    assign s_tready = (state_reg == ST_LOAD);
    assign s_accept = s_tvalid && s_tready;
    assign in_range = (32'(src_vertex) < 32'(MAX_VERTICES)) &&
                      (32'(dst_vertex) < 32'(MAX_VERTICES));

    // vertex count: zero acts as one, saturates at the built size
    assign nv_ext = NC_W'(num_vertices_reg);
    always_comb begin
        if (num_vertices_reg == '0) begin
            n_used = CNT_W'(1);
        end else if (nv_ext > NC_W'(MAX_VERTICES)) begin
            n_used = CNT_W'(MAX_VERTICES);
        end else begin
            n_used = CNT_W'(nv_ext);
        end
    end

    assign res_ack     = (state_reg == ST_RUN) && res_valid && (!out_valid_reg || m_tready);
    assign clear_start = res_ack;
    assign tree_start  = s_accept && s_tlast;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (!clear_busy) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (tree_start) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (res_ack) begin
                    state_next = ST_CLEAR;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (res_ack) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_CLEAR;
            out_valid_reg    <= 1'b0;
            num_vertices_reg <= NUM_VERTICES_RST;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid) begin
                num_vertices_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ack) begin
            out_total_reg <= result.total_weight;
            out_gap_reg   <= result.disconnected;
        end
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(M_TDATA_W-TOTAL_W){1'b0}}, out_total_reg};
    assign m_tuser   = out_gap_reg;

    prim_mst_matrix #(
        .MAX_VERTICES (MAX_VERTICES),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_matrix (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .clear_start (clear_start),
        .clear_busy  (clear_busy),
        .wr_en       (s_accept && in_range),
        .wr_a        (VTX_W'(src_vertex)),
        .wr_b        (VTX_W'(dst_vertex)),
        .wr_data     (WEIGHT_BITS'(weight)),
        .rd_en       (mat_rd_en),
        .rd_a        (mat_rd_a),
        .rd_b        (mat_rd_b),
        .rd_data     (mat_rd_data)
    );

    prim_mst_tree #(
        .MAX_VERTICES (MAX_VERTICES),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_tree (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (tree_start),
        .n_used      (n_used),
        .mat_rd_en   (mat_rd_en),
        .mat_rd_a    (mat_rd_a),
        .mat_rd_b    (mat_rd_b),
        .mat_rd_data (mat_rd_data),
        .res_valid   (res_valid),
        .res_ack     (res_ack),
        .result      (result)
    );

endmodule
